### hdl/fdbd_pkg.sv
// Shared types and constants of the first-duplicate detector.
`timescale 1ns / 1ps

package fdbd_pkg;

   // Width of one set element and the largest map the element width can index.
   localparam int unsigned VALUE_W     = 14;
   localparam int unsigned VALUE_LIMIT = 16384;

   // Set tags stored in the map. Tag zero marks an entry as never seen.
   localparam int unsigned EPOCH_W   = 8;
   localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;

   // Depths of the queue between front and back and of the result queue.
   localparam int unsigned MID_DEPTH = 4;
   localparam int unsigned OUT_DEPTH = 4;

   // One request: a set element and its end-of-set mark.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
   } req_type;

   // One result: the first repeated value and its flag.
   typedef struct packed {
      logic [VALUE_W-1:0] dup_value;
      logic               dup_found;
   } rsp_type;

   // A classified request on its way from the front to the back.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
      logic               in_range;
      logic [EPOCH_W-1:0] tag;
      logic               wrap;
   } mid_item_type;

   // Status reported by the back to the front.
   typedef struct packed {
      logic clear_done;
   } back_status_type;

endpackage

### hdl/fdbd_fifo.sv
// Small register-based first-in first-out queue with an occupancy count.
`timescale 1ns / 1ps

module fdbd_fifo #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             push_data,
   output logic                         full,
   input  logic                         pop,
   output logic [WIDTH-1:0]             pop_data,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots carry no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/fdbd_front.sv
// Front part: accepts requests, range-checks them and tags them with their set.
`timescale 1ns / 1ps

module fdbd_front #(
   parameter int unsigned VALUE_COUNT = 16384
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  fdbd_pkg::req_type         req_data,
   output logic                      req_full,
   input  logic                      mid_full,
   output logic                      mid_push,
   output fdbd_pkg::mid_item_type    mid_data,
   input  fdbd_pkg::back_status_type back_status
);

   import fdbd_pkg::*;

   localparam int unsigned MAP_DEPTH = (VALUE_COUNT < VALUE_LIMIT) ? VALUE_COUNT : VALUE_LIMIT;

   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic               wait_ff, wait_in;
   logic               accept;
   logic               wrap;

   // Hold off requests while the map is being cleared or the queue is full.
   assign req_full = wait_ff || mid_full;
   assign accept   = req_push && !req_full;
   assign wrap     = req_data.last && (epoch_ff == EPOCH_MAX);

   // Classify the request and tag it with the current set.
   always_comb begin
      mid_data.value    = req_data.value;
      mid_data.last     = req_data.last;
      mid_data.in_range = (32'(req_data.value) < MAP_DEPTH);
      mid_data.tag      = epoch_ff;
      mid_data.wrap     = wrap;
   end
   assign mid_push = accept;

   // Advance the set tag at every end of set; wait for a clear when tags run out.
   always_comb begin
      epoch_in = epoch_ff;
      wait_in  = wait_ff;
      if (back_status.clear_done) begin
         wait_in = 1'b0;
      end
      if (accept && req_data.last) begin
         if (wrap) begin
            epoch_in = EPOCH_FIRST;
            wait_in  = 1'b1;
         end else begin
            epoch_in = epoch_ff + EPOCH_W'(1);
         end
      end
   end

   // The back clears the map after reset, so the front starts out waiting.
   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= EPOCH_FIRST;
         wait_ff  <= 1'b1;
      end else begin
         epoch_ff <= epoch_in;
         wait_ff  <= wait_in;
      end
   end

endmodule

### hdl/fdbd_back.sv
// Back part: seen-map memory, read-modify-write per element, duplicate latch.
`timescale 1ns / 1ps

module fdbd_back #(
   parameter int unsigned VALUE_COUNT = 16384
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             mid_empty,
   input  fdbd_pkg::mid_item_type           mid_data,
   output logic                             mid_pop,
   input  logic [$clog2(fdbd_pkg::OUT_DEPTH+1)-1:0] out_count,
   output logic                             out_push,
   output fdbd_pkg::rsp_type                out_data,
   output fdbd_pkg::back_status_type        back_status
);

   import fdbd_pkg::*;

   localparam int unsigned MAP_DEPTH = (VALUE_COUNT < VALUE_LIMIT) ? VALUE_COUNT : VALUE_LIMIT;
   localparam int unsigned ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

   logic [EPOCH_W-1:0] map_mem [MAP_DEPTH];
   logic [EPOCH_W-1:0] rd_data_ff;

   mid_item_type       s1_item_ff;
   logic               s1_valid_ff;
   logic               lw_valid_ff;
   logic [ADDR_W-1:0]  lw_addr_ff;
   logic [EPOCH_W-1:0] lw_tag_ff;
   logic               found_ff, found_in;
   logic [VALUE_W-1:0] found_val_ff, found_val_in;
   logic               clearing_ff;
   logic [ADDR_W-1:0]  clr_addr_ff;

   logic [ADDR_W-1:0]  s1_addr;
   logic               seen;
   logic               eligible;
   logic               mark;
   logic               clr_last;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [EPOCH_W-1:0] wr_data;

   // Take a request only when the result queue has room for everything in flight.
   assign mid_pop = !clearing_ff && !mid_empty &&
                    ((32'(out_count) + 32'(s1_valid_ff)) < OUT_DEPTH);

   // An entry is seen when it holds this set's tag, either in memory or in
   // the write made in the previous cycle that the read could not yet observe.
   assign s1_addr  = s1_item_ff.value[ADDR_W-1:0];
   assign seen     = (rd_data_ff == s1_item_ff.tag) ||
                     (lw_valid_ff && (lw_addr_ff == s1_addr) && (lw_tag_ff == s1_item_ff.tag));
   assign eligible = s1_valid_ff && s1_item_ff.in_range && !found_ff;
   assign mark     = eligible && !seen;

   // Duplicate latch and result of the set.
   always_comb begin
      found_in     = found_ff;
      found_val_in = found_val_ff;
      if (eligible && seen) begin
         found_in     = 1'b1;
         found_val_in = s1_item_ff.value;
      end
      out_push           = s1_valid_ff && s1_item_ff.last;
      out_data.dup_found = found_in;
      out_data.dup_value = found_in ? found_val_in : '0;
      if (out_push) begin
         found_in     = 1'b0;
         found_val_in = '0;
      end
   end

   // The write port serves either the clearing sweep or the element marks.
   assign clr_last = (clr_addr_ff == ADDR_W'(MAP_DEPTH-1));
   assign back_status.clear_done = clearing_ff && clr_last;
   always_comb begin
      if (clearing_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = EPOCH_NONE;
      end else begin
         wr_en   = mark;
         wr_addr = s1_addr;
         wr_data = s1_item_ff.tag;
      end
   end

   // Seen-map memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (mid_pop) begin
         rd_data_ff <= map_mem[mid_data.value[ADDR_W-1:0]];
      end
   end

   // Element stage, write bypass, latch and clearing sweep control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         lw_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         found_val_ff <= '0;
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
      end else begin
         s1_valid_ff  <= mid_pop;
         lw_valid_ff  <= !clearing_ff && mark;
         found_ff     <= found_in;
         found_val_ff <= found_val_in;
         if (clearing_ff) begin
            clr_addr_ff <= clr_last ? '0 : clr_addr_ff + ADDR_W'(1);
            if (clr_last) begin
               clearing_ff <= 1'b0;
            end
         end else if (s1_valid_ff && s1_item_ff.last && s1_item_ff.wrap) begin
            clearing_ff <= 1'b1;
            clr_addr_ff <= '0;
         end
      end
   end

   // Stage payload needs no reset.
   always_ff @(posedge clock) begin
      if (mid_pop) begin
         s1_item_ff <= mid_data;
      end
      lw_addr_ff <= s1_addr;
      lw_tag_ff  <= s1_item_ff.tag;
   end

endmodule

### hdl/first_duplicate_bitmap_detector_core.sv
// Top level of the first-duplicate detector: front, queues and back.
//
// Requests enter through req_push / req_full; each carries one set element and
// a last mark. Results leave through rsp_empty / rsp_pop, one per set, issued
// on the request marked last: the first value that repeated within the set,
// and its found flag (value 0 and flag clear when nothing repeated).
// Throughput is one request per cycle while req_full is low, set by the single
// read-modify-write of the seen map per element; a write bypass covers
// back-to-back equal values. An accepted request passes the internal queue and
// the element stage before its result is registered in the result queue.
// The map is not swept at each set: every entry stores the tag of the set that
// marked it, and a new set simply uses a new tag. After reset, and after every
// 255 sets when the tags run out, a clearing pass writes every map entry
// (min(VALUE_COUNT, 16384) of them); req_full stays high during it.
// When the receiver stalls, results wait in a four-entry queue and requests
// keep flowing until that queue and the internal queue fill, then req_full
// rises. Reset is synchronous and empties both queues.
`timescale 1ns / 1ps

module first_duplicate_bitmap_detector_core #(
   parameter int unsigned VALUE_COUNT = 16384
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  fdbd_pkg::req_type req_data,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output fdbd_pkg::rsp_type rsp_data
);

   import fdbd_pkg::*;

   localparam int unsigned MID_W = $bits(mid_item_type);
   localparam int unsigned RSP_W = $bits(rsp_type);

   logic                           mid_push;
   mid_item_type                   mid_in;
   logic                           mid_full;
   logic                           mid_pop;
   logic [MID_W-1:0]               mid_out_bits;
   mid_item_type                   mid_out;
   logic                           mid_empty;
   logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
   back_status_type                back_status;
   logic                           out_push;
   rsp_type                        out_data;
   logic [RSP_W-1:0]               rsp_bits;
   logic                           out_full;
   logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

   // Front: request acceptance and classification.
   fdbd_front #(
      .VALUE_COUNT (VALUE_COUNT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_data    (req_data),
      .req_full    (req_full),
      .mid_full    (mid_full),
      .mid_push    (mid_push),
      .mid_data    (mid_in),
      .back_status (back_status)
   );

   // Queue between front and back.
   fdbd_fifo #(
      .WIDTH (MID_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_out_bits),
      .empty     (mid_empty),
      .count     (mid_count)
   );
   assign mid_out = mid_item_type'(mid_out_bits);

   // Back: seen map and duplicate latch.
   fdbd_back #(
      .VALUE_COUNT (VALUE_COUNT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .mid_empty   (mid_empty || (mid_count == '0)),
      .mid_data    (mid_out),
      .mid_pop     (mid_pop),
      .out_count   (out_count),
      .out_push    (out_push),
      .out_data    (out_data),
      .back_status (back_status)
   );

   // Result queue; the back never pushes into it when full.
   fdbd_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (OUT_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push && !out_full),
      .push_data (out_data),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .empty     (rsp_empty),
      .count     (out_count)
   );
   assign rsp_data = rsp_type'(rsp_bits);

endmodule
